>>> hw/rtl/ptrs_symbol_mask_gen_unit_defines.svh
// Assertion macros for the PTRS symbol mask generator.
// Included by the top level; expects clk and rst_n in scope.
`ifndef PTRS_SYMBOL_MASK_GEN_UNIT_DEFINES_SVH
`define PTRS_SYMBOL_MASK_GEN_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PSMG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSMG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/psmg_pkg.sv
// Shared types and constants for the PTRS symbol mask generator.
// Holds the control store layout and the microprogram; no dependencies.
package psmg_pkg;

    localparam int SYM_W      = 5;   // symbol index, candidate and end position
    localparam int SYM_MAX    = 16;  // widest slot the datapath covers
    localparam int IDX_W      = 4;   // bit index into a slot-wide vector
    localparam int FIRST_W    = 4;
    localparam int COUNT_W    = 4;
    localparam int SPACING_W  = 3;
    localparam int MASK_W     = 14;
    localparam int UPC_W      = 3;

    // Jump conditions
    localparam logic [2:0] COND_IN     = 3'd0;
    localparam logic [2:0] COND_ZERO   = 3'd1;
    localparam logic [2:0] COND_DONE   = 3'd2;
    localparam logic [2:0] COND_OUT    = 3'd3;
    localparam logic [2:0] COND_ALWAYS = 3'd4;

    // Microprogram addresses
    localparam logic [UPC_W-1:0] STEP_IDLE  = 3'd0;
    localparam logic [UPC_W-1:0] STEP_CHECK = 3'd1;
    localparam logic [UPC_W-1:0] STEP_SCAN  = 3'd2;
    localparam logic [UPC_W-1:0] STEP_EMIT  = 3'd3;
    localparam logic [UPC_W-1:0] STEP_BAD   = 3'd4;

    typedef struct packed {
        logic             take_in;
        logic             scan;
        logic             emit;
        logic             bad;
        logic [2:0]       cond;
        logic             stay;   // hold the step when the condition is false
        logic [UPC_W-1:0] target;
    } word_t;

    typedef struct packed {
        logic in_valid;
        logic zero_spacing;
        logic walk_done;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic in_ready;
        logic load;
        logic scan;
        logic emit;
        logic bad;
    } ctrl_t;

    function automatic word_t rom_word(input logic [UPC_W-1:0] addr);
        word_t w;
        w = '0;
        unique case (addr)
            STEP_IDLE:
                w = '{take_in: 1'b1, scan: 1'b0, emit: 1'b0, bad: 1'b0,
                      cond: COND_IN, stay: 1'b1, target: STEP_CHECK};
            STEP_CHECK:
                w = '{take_in: 1'b0, scan: 1'b0, emit: 1'b0, bad: 1'b0,
                      cond: COND_ZERO, stay: 1'b0, target: STEP_BAD};
            STEP_SCAN:
                w = '{take_in: 1'b0, scan: 1'b1, emit: 1'b0, bad: 1'b0,
                      cond: COND_DONE, stay: 1'b1, target: STEP_EMIT};
            STEP_EMIT:
                w = '{take_in: 1'b0, scan: 1'b0, emit: 1'b1, bad: 1'b0,
                      cond: COND_OUT, stay: 1'b1, target: STEP_IDLE};
            STEP_BAD:
                w = '{take_in: 1'b0, scan: 1'b0, emit: 1'b1, bad: 1'b1,
                      cond: COND_OUT, stay: 1'b1, target: STEP_IDLE};
            default:
                w = '{take_in: 1'b0, scan: 1'b0, emit: 1'b0, bad: 1'b0,
                      cond: COND_ALWAYS, stay: 1'b0, target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hw/rtl/psmg_seq.sv
// Microcode sequencer: step counter, control store and jump logic.
// Depends on psmg_pkg for the control word layout and the microprogram.
module psmg_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  psmg_pkg::status_t status,
    output psmg_pkg::ctrl_t   ctrl
);
    import psmg_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    word_t            w;
    logic             taken;

    always_comb
    begin
        w = rom_word(upc_reg);
        unique case (w.cond)
            COND_IN:     taken = status.in_valid;
            COND_ZERO:   taken = status.zero_spacing;
            COND_DONE:   taken = status.walk_done;
            COND_OUT:    taken = status.out_free;
            COND_ALWAYS: taken = 1'b1;
            default:     taken = 1'b0;
        endcase

        priority if (taken)
            upc_next = w.target;
        else if (w.stay)
            upc_next = upc_reg;
        else
            upc_next = upc_reg + 1'b1;

        ctrl.in_ready = w.take_in;
        ctrl.load     = w.take_in & taken;
        ctrl.scan     = w.scan & ~taken;
        ctrl.emit     = w.emit & taken;
        ctrl.bad      = w.bad;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= STEP_IDLE;
        else
            upc_reg <= upc_next;
    end

endmodule

>>> hw/rtl/ptrs_symbol_mask_gen_unit.sv
// PTRS time-domain symbol mask generator, top level: walk datapath and output register.
// Depends on psmg_pkg, psmg_seq and ptrs_symbol_mask_gen_unit_defines.svh.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   s_tdata: allocation and DMRS bitmap
//   m_*      out  m_tvalid/m_tready   m_tdata: PTRS bitmap, m_tuser: bad spacing
//
// The scan step of the microprogram visits one symbol a cycle, walking n symbols (at
// most SLOT_SYMBOLS) before the result is loaded into the output register; a zero
// spacing skips the scan step. One item is in flight at a time; the next can be taken
// in the cycle in which the result first sits in the output register. A stalled output
// holds the sequencer in its emit or bad step. Reset clears the step counter and m_tvalid.
module ptrs_symbol_mask_gen_unit #(
    parameter int SLOT_SYMBOLS = 14
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [3:0] first_symbol, [7:4] symbol_count, [10:8] time_spacing,
    // [24:11] dmrs_mask, [31:25] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [13:0] ptrs_mask, [15:14] zero
    output logic [15:0] m_tdata,
    // [0] bad_spacing
    output logic [0:0]  m_tuser
);
    import psmg_pkg::*;

    `include "ptrs_symbol_mask_gen_unit_defines.svh"

    status_t status;
    ctrl_t   ctrl;

    logic [SYM_W-1:0]     k_reg, k_next;
    logic [SYM_W-1:0]     cand_reg, cand_next;
    logic [SYM_W-1:0]     end_reg, end_next;
    logic [SPACING_W-1:0] spacing_reg, spacing_next;
    logic [MASK_W-1:0]    dmrs_reg, dmrs_next;
    logic [IDX_W-1:0]     latest_reg, latest_next;
    logic                 latest_v_reg, latest_v_next;
    logic [SYM_MAX-1:0]   mask_reg, mask_next;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [MASK_W-1:0]    out_mask_reg, out_mask_next;
    logic                 out_bad_reg, out_bad_next;

    logic [SYM_MAX-1:0]   dmrs_ext;
    logic [IDX_W-1:0]     k_idx;
    logic                 sym_dmrs;
    logic [SYM_W-1:0]     step_ext;

    psmg_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign dmrs_ext = {{(SYM_MAX - MASK_W){1'b0}}, dmrs_reg};
    assign k_idx    = k_reg[IDX_W-1:0];
    assign sym_dmrs = dmrs_ext[k_idx];
    assign step_ext = {{(SYM_W - SPACING_W){1'b0}}, spacing_reg};

    always_comb
    begin
        status.in_valid     = s_tvalid;
        status.zero_spacing = (spacing_reg == '0);
        status.walk_done    = (k_reg >= end_reg) || (k_reg >= SYM_W'(SLOT_SYMBOLS));
        status.out_free     = ~m_tvalid_reg | m_tready;
    end

    // Walk datapath: one symbol per scan cycle
    always_comb
    begin
        k_next        = k_reg;
        cand_next     = cand_reg;
        end_next      = end_reg;
        spacing_next  = spacing_reg;
        dmrs_next     = dmrs_reg;
        latest_next   = latest_reg;
        latest_v_next = latest_v_reg;
        mask_next     = mask_reg;

        if (ctrl.load)
        begin
            k_next        = {1'b0, s_tdata[3:0]};
            cand_next     = {1'b0, s_tdata[3:0]};
            end_next      = {1'b0, s_tdata[3:0]} + {1'b0, s_tdata[7:4]};
            spacing_next  = s_tdata[10:8];
            dmrs_next     = s_tdata[24:11];
            latest_v_next = 1'b0;
            mask_next     = '0;
        end
        else if (ctrl.scan)
        begin
            k_next = k_reg + 1'b1;
            if (k_reg == cand_reg)
            begin
                // DMRS on the candidate or earlier in its span: restart from it
                priority if (sym_dmrs)
                    cand_next = k_reg + step_ext;
                else if (latest_v_reg)
                    cand_next = {1'b0, latest_reg} + step_ext;
                else
                begin
                    mask_next[k_idx] = 1'b1;
                    cand_next        = k_reg + step_ext;
                end
                latest_v_next = 1'b0;
            end
            else if (sym_dmrs)
            begin
                latest_v_next = 1'b1;
                latest_next   = k_idx;
            end
        end
    end

    // Output register
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        out_mask_next = out_mask_reg;
        out_bad_next  = out_bad_reg;
        if (ctrl.emit)
        begin
            m_tvalid_next = 1'b1;
            out_mask_next = ctrl.bad ? '0 : mask_reg[MASK_W-1:0];
            out_bad_next  = ctrl.bad;
        end
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        cand_reg     <= cand_next;
        end_reg      <= end_next;
        spacing_reg  <= spacing_next;
        dmrs_reg     <= dmrs_next;
        latest_reg   <= latest_next;
        latest_v_reg <= latest_v_next;
        mask_reg     <= mask_next;
        out_mask_reg <= out_mask_next;
        out_bad_reg  <= out_bad_next;
    end

    assign s_tready = ctrl.in_ready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(16 - MASK_W){1'b0}}, out_mask_reg};
    assign m_tuser  = out_bad_reg;

    `PSMG_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "item taken while busy")
    `PSMG_ASSERT_NOW(a_bad_is_empty, m_tvalid && m_tuser[0], m_tdata == 16'd0, "bad spacing with mask")
    `PSMG_ASSERT_NOW(a_mask_in_slot, ctrl.scan, (mask_reg >> SLOT_SYMBOLS) == '0, "mask past slot end")
    `PSMG_ASSERT_NOW(a_emit_free, ctrl.emit, !m_tvalid || m_tready, "result overwritten")

endmodule

>>> bench/tb.sv
// Self-checking bench for ptrs_symbol_mask_gen_unit: allocations in on the s_ stream,
// PTRS masks out on the m_ stream, checked against an in-bench symbol walk.
// Depends on psmg_pkg and the RTL of ptrs_symbol_mask_gen_unit only.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psmg_pkg::*;

    localparam int SLOT_SYMBOLS = 14;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE       = SLOT_SYMBOLS + 8;

    typedef struct packed {
        logic [MASK_W-1:0] ptrs_mask;
        logic              bad_spacing;
    } ptrs_result_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_e;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    ptrs_result_t expected_ptrs[$];
    rx_mode_e     rx_mode = RX_ALWAYS;
    bit           tx_gaps = 1'b0;
    int           burst_left = 0;
    int           hold_off_req = 0;
    int           hold_off_left = 0;
    int           hold_offs_done = 0;
    int           cycle_count = 0;
    int           fail_count = 0;
    int           allocs_sent = 0;
    int           masks_checked = 0;
    int           bad_seen = 0;

    ptrs_symbol_mask_gen_unit #(
        .SLOT_SYMBOLS(SLOT_SYMBOLS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[ptrs_symbol_mask_gen_unit] ERROR");
            $finish;
        end
    end

    // Walk the allocation symbol by symbol; a DMRS symbol in the span since the
    // last candidate becomes the new anchor and stepping restarts from it.
    function automatic logic [MASK_W-1:0] ptrs_positions(
        input logic [FIRST_W-1:0]   first,
        input logic [COUNT_W-1:0]   count,
        input logic [SPACING_W-1:0] spacing,
        input logic [MASK_W-1:0]    dmrs
    );
        logic [MASK_W-1:0] mask;
        int step, last_sym, anchor, i, pos, low, k, hit;
        mask = '0;
        step = int'(spacing);
        if (step == 0)
            return mask;
        last_sym = int'(first) + int'(count) - 1;
        if (last_sym > SLOT_SYMBOLS - 1)
            last_sym = SLOT_SYMBOLS - 1;
        anchor = int'(first);
        i = 0;
        while (anchor + i * step <= last_sym)
        begin
            pos = anchor + i * step;
            low = anchor + (i - 1) * step + 1;
            if (low < anchor)
                low = anchor;
            hit = -1;
            for (k = pos; k >= low; k--)
                if (hit < 0 && k < MASK_W && dmrs[k])
                    hit = k;
            if (hit >= 0)
            begin
                anchor = hit;
                i = 1;
            end
            else
            begin
                if (pos < MASK_W)
                    mask[pos] = 1'b1;
                i++;
            end
        end
        return mask;
    endfunction

    task automatic send_alloc(
        input logic [FIRST_W-1:0]   first,
        input logic [COUNT_W-1:0]   count,
        input logic [SPACING_W-1:0] spacing,
        input logic [MASK_W-1:0]    dmrs
    );
        ptrs_result_t res;
        res.ptrs_mask   = ptrs_positions(first, count, spacing, dmrs);
        res.bad_spacing = (spacing == 0);
        if (tx_gaps && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        s_tdata  <= {7'd0, dmrs, spacing, count, first};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_ptrs.push_back(res);
        allocs_sent++;
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and hold until every mask is back and the block has settled.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (expected_ptrs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Receiver: a long hold-off when asked, else the current stall pattern.
    always @(posedge clk)
    begin
        if (hold_off_req != 0)
        begin
            hold_off_left = hold_off_req;
            hold_off_req = 0;
        end
        if (hold_off_left > 0)
        begin
            m_tready <= 1'b0;
            hold_off_left--;
            if (hold_off_left == 0)
                hold_offs_done++;
        end
        else
        begin
            case (rx_mode)
                RX_ALWAYS:  m_tready <= 1'b1;
                RX_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
                default:    m_tready <= ((cycle_count % 7) < 3);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_ptrs.size() == 0)
            begin
                $error("unexpected result: ptrs_mask 0x%04h bad_spacing %0d",
                       m_tdata[MASK_W-1:0], m_tuser[0]);
                fail_count++;
            end
            else
            begin
                ptrs_result_t exp_res;
                exp_res = expected_ptrs.pop_front();
                masks_checked++;
                if (m_tuser[0])
                    bad_seen++;
                if (m_tdata[MASK_W-1:0] !== exp_res.ptrs_mask)
                begin
                    $error("ptrs_mask: expected 0x%04h, got 0x%04h",
                           exp_res.ptrs_mask, m_tdata[MASK_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[15:MASK_W] !== '0)
                begin
                    $error("m_tdata padding: expected 0, got 0x%0h", m_tdata[15:MASK_W]);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_res.bad_spacing)
                begin
                    $error("bad_spacing: expected %0d, got %0d",
                           exp_res.bad_spacing, m_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_bad_spacing;
        send_alloc(4'd0, 4'd14, 3'd0, 14'h0804);
        send_alloc(4'd15, 4'd15, 3'd0, 14'h3FFF);
        drain();
    endtask

    task automatic test_full_slot;
        send_alloc(4'd0, 4'd14, 3'd1, 14'h0000);
        send_alloc(4'd0, 4'd14, 3'd2, 14'h0000);
        send_alloc(4'd0, 4'd14, 3'd3, 14'h0004);
        send_alloc(4'd0, 4'd14, 3'd4, 14'h0804);
        send_alloc(4'd2, 4'd12, 3'd1, 14'h0804);
        drain();
    endtask

    task automatic test_clamp_and_empty;
        send_alloc(4'd3, 4'd0, 3'd1, 14'h0000);   // no symbols
        send_alloc(4'd14, 4'd5, 3'd1, 14'h0000);  // starts past slot end
        send_alloc(4'd15, 4'd15, 3'd2, 14'h0000);
        send_alloc(4'd10, 4'd15, 3'd1, 14'h0000); // runs past slot end
        send_alloc(4'd13, 4'd1, 3'd1, 14'h0000);
        drain();
    endtask

    task automatic test_wide_spacing;
        send_alloc(4'd0, 4'd14, 3'd5, 14'h0000);
        send_alloc(4'd1, 4'd13, 3'd6, 14'h0010);
        send_alloc(4'd0, 4'd15, 3'd7, 14'h0000);
        drain();
    endtask

    task automatic test_dmrs_restart;
        send_alloc(4'd0, 4'd14, 3'd1, 14'h3FFF);
        send_alloc(4'd2, 4'd12, 3'd2, 14'h0004);  // DMRS on the first symbol
        send_alloc(4'd0, 4'd14, 3'd4, 14'h0108);
        send_alloc(4'd1, 4'd13, 3'd3, 14'h2000);
        drain();
    endtask

    // Long output hold-off while the sender keeps offering: the input must stall.
    task automatic test_backpressure;
        tx_gaps = 1'b0;
        hold_off_req = 400;
        repeat (12)
            send_alloc(FIRST_W'($urandom_range(0, 13)), COUNT_W'($urandom_range(1, 14)),
                       SPACING_W'($urandom_range(1, 4)), MASK_W'($urandom_range(0, 16383)));
        drain();
    endtask

    task automatic test_drain_pause;
        tx_gaps = 1'b1;
        rx_mode = RX_RANDOM;
        repeat (3)
        begin
            repeat ($urandom_range(3, 10))
                send_alloc(FIRST_W'($urandom_range(0, 13)), COUNT_W'($urandom_range(1, 14)),
                           SPACING_W'($urandom_range(0, 4)),
                           MASK_W'($urandom_range(0, 16383)));
            drain();
        end
    endtask

    task automatic test_random;
        logic [FIRST_W-1:0]   first;
        logic [COUNT_W-1:0]   count;
        logic [SPACING_W-1:0] spacing;
        logic [MASK_W-1:0]    dmrs;
        for (int n = 0; n < 1100; n++)
        begin
            // Shift the handshake pressure every so often, calm stretches included.
            if (n % 150 == 0)
            begin
                rx_mode = rx_mode_e'($urandom_range(0, 2));
                tx_gaps = ($urandom_range(0, 1) != 0);
            end
            if ($urandom_range(0, 99) < 85)
            begin
                first   = FIRST_W'($urandom_range(0, 13));
                count   = COUNT_W'($urandom_range(1, 14));
                spacing = SPACING_W'($urandom_range(1, 4));
                dmrs    = MASK_W'(($urandom_range(0, 1) ? $urandom & $urandom : $urandom)
                                  & 14'h3FFF);
            end
            else
            begin
                first   = FIRST_W'($urandom);
                count   = COUNT_W'($urandom);
                spacing = SPACING_W'($urandom);
                dmrs    = MASK_W'($urandom);
            end
            send_alloc(first, count, spacing, dmrs);
        end
        drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_bad_spacing();
        test_full_slot();
        test_clamp_and_empty();
        test_wide_spacing();
        test_dmrs_restart();
        test_backpressure();
        test_drain_pause();
        test_random();
        repeat (SETTLE) @(posedge clk);
        if (expected_ptrs.size() != 0)
        begin
            $error("%0d masks never arrived", expected_ptrs.size());
            fail_count++;
        end
        $display("run: %0d allocations sent, %0d masks checked, %0d with zero spacing",
                 allocs_sent, masks_checked, bad_seen);
        $display("run: %0d long output hold-offs, %0d cycles", hold_offs_done, cycle_count);
        if (fail_count == 0)
            $display("[ptrs_symbol_mask_gen_unit] OK");
        else
            $display("[ptrs_symbol_mask_gen_unit] ERROR");
        $finish;
    end

endmodule
